@@ rtl/sit_pkg.sv @@
// ----------------------------------------------------------------------------
// sit_pkg
// Shared command and status codes for the sorted insertion table.
// ----------------------------------------------------------------------------
package sit_pkg;

   // Command selector carried on the request tuser
   localparam int CMD_W = 2;
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

   // Result status carried on the response tuser
   localparam int STATUS_W = 2;
   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd2;

endpackage

@@ rtl/sit_mem.sv @@
// ----------------------------------------------------------------------------
// sit_mem
// Entry storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sit_mem #(
   parameter int DEPTH  = 64,
   parameter int DATA_W = 32,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data_ff
);

   logic [DATA_W-1:0] mem_ff [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, data valid the cycle after the address
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

@@ rtl/sorted_insertion_table.sv @@
// Sorted insertion table: entries kept in ascending key order, stable on ties.
// Insert: every entry with a greater key moves up one place, one entry per cycle,
//   through the single memory read/write port pair; the new entry fills the gap.
// Read: the entry at the given rank is read from memory; clear, full insert and missing
// read need no memory access. One request at a time; accepted while the last response waits.
// Synchronous active-high reset empties the table; entry contents are not cleared.
// ----------------------------------------------------------------------------
// sorted_insertion_table
// Stable sorted table with insert, read-by-rank and clear requests, driven by
// a small sequencer around one memory and one key comparator.
// ----------------------------------------------------------------------------
module sorted_insertion_table #(
   parameter int CAPACITY  = 64,
   parameter int KEY_WIDTH = 16,
   parameter int TAG_WIDTH = 16,
   localparam int RANK_W     = $clog2(CAPACITY),
   localparam int CNT_W      = $clog2(CAPACITY + 1),
   localparam int REQ_BITS   = KEY_WIDTH + TAG_WIDTH + RANK_W,
   localparam int REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8,
   localparam int RSP_BITS   = KEY_WIDTH + TAG_WIDTH + CNT_W,
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [REQ_DATA_W-1:0]         req_tdata,  // key_in, tag_in, rank
   input  logic [sit_pkg::CMD_W-1:0]     req_tuser,  // command
   // response channel
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [RSP_DATA_W-1:0]         rsp_tdata,  // key_out, tag_out, count
   output logic [sit_pkg::STATUS_W-1:0]  rsp_tuser   // status
);

   localparam int ADDR_W = RANK_W;
   localparam int ENTRY_W = KEY_WIDTH + TAG_WIDTH;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_PLACE,
      ST_READ,
      ST_RESULT
   } state_type;

   state_type                     state_ff, state_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [CNT_W-1:0]              pos_ff, pos_in;
   logic [KEY_WIDTH-1:0]          key_ff, key_in;
   logic [TAG_WIDTH-1:0]          tag_ff, tag_in;
   logic [sit_pkg::STATUS_W-1:0]  res_status_ff, res_status_in;
   logic [KEY_WIDTH-1:0]          res_key_ff, res_key_in;
   logic [TAG_WIDTH-1:0]          res_tag_ff, res_tag_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [sit_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [KEY_WIDTH-1:0]          rsp_key_ff, rsp_key_in;
   logic [TAG_WIDTH-1:0]          rsp_tag_ff, rsp_tag_in;
   logic [CNT_W-1:0]              rsp_count_ff, rsp_count_in;

   logic                          mem_wr_en;
   logic [ADDR_W-1:0]             mem_wr_addr;
   logic [ENTRY_W-1:0]            mem_wr_data;
   logic [ADDR_W-1:0]             mem_rd_addr;
   logic [ENTRY_W-1:0]            mem_rd_data;

   logic [KEY_WIDTH-1:0]          req_key;
   logic [TAG_WIDTH-1:0]          req_tag;
   logic [RANK_W-1:0]             req_rank;
   logic                          req_fire;
   logic                          mem_key_greater;

   // Request unpacking
   assign req_key  = req_tdata[KEY_WIDTH-1:0];
   assign req_tag  = req_tdata[KEY_WIDTH +: TAG_WIDTH];
   assign req_rank = req_tdata[ENTRY_W +: RANK_W];
   assign req_fire = req_tvalid && req_tready;

   assign req_tready = (state_ff == ST_IDLE);

   // Single comparator: stored key against the key being inserted
   assign mem_key_greater = (mem_rd_data[KEY_WIDTH-1:0] > key_ff);

   sit_mem #(
      .DEPTH  (CAPACITY),
      .DATA_W (ENTRY_W)
   ) u_mem (
      .clock      (clock),
      .wr_en      (mem_wr_en),
      .wr_addr    (mem_wr_addr),
      .wr_data    (mem_wr_data),
      .rd_addr    (mem_rd_addr),
      .rd_data_ff (mem_rd_data)
   );

   // Sequencer next state and memory control
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      key_in        = key_ff;
      tag_in        = tag_ff;
      res_status_in = res_status_ff;
      res_key_in    = res_key_ff;
      res_tag_in    = res_tag_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_count_in  = rsp_count_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = ADDR_W'(pos_ff);
      mem_wr_data   = {tag_ff, key_ff};
      mem_rd_addr   = ADDR_W'(pos_ff - CNT_W'(2));

      case (state_ff)
         ST_IDLE: begin
            if (req_tuser == sit_pkg::CMD_READ) begin
               mem_rd_addr = req_rank;
            end else begin
               mem_rd_addr = ADDR_W'(count_ff - CNT_W'(1));
            end
            if (req_fire) begin
               key_in        = req_key;
               tag_in        = req_tag;
               pos_in        = count_ff;
               res_status_in = sit_pkg::STATUS_OK;
               res_key_in    = '0;
               res_tag_in    = '0;
               state_in      = ST_RESULT;
               case (req_tuser)
                  sit_pkg::CMD_INSERT: begin
                     if (count_ff == CNT_W'(CAPACITY)) begin
                        res_status_in = sit_pkg::STATUS_FULL;
                     end else if (count_ff == '0) begin
                        state_in = ST_PLACE;
                     end else begin
                        state_in = ST_SHIFT;
                     end
                  end
                  sit_pkg::CMD_READ: begin
                     if (CNT_W'(req_rank) >= count_ff) begin
                        res_status_in = sit_pkg::STATUS_MISSING;
                     end else begin
                        state_in = ST_READ;
                     end
                  end
                  sit_pkg::CMD_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // Move one greater entry up per cycle, next read issued; else place the new entry
         ST_SHIFT: begin
            mem_wr_en = 1'b1;
            if (mem_key_greater) begin
               mem_wr_data = mem_rd_data;
               pos_in      = pos_ff - CNT_W'(1);
               if (pos_ff == CNT_W'(1)) begin
                  state_in = ST_PLACE;
               end
            end else begin
               count_in = count_ff + CNT_W'(1);
               state_in = ST_RESULT;
            end
         end

         // New entry lands at the bottom of the table
         ST_PLACE: begin
            mem_wr_en = 1'b1;
            count_in  = count_ff + CNT_W'(1);
            state_in  = ST_RESULT;
         end

         ST_READ: begin
            res_key_in = mem_rd_data[KEY_WIDTH-1:0];
            res_tag_in = mem_rd_data[KEY_WIDTH +: TAG_WIDTH];
            state_in   = ST_RESULT;
         end

         // Hand result to the output register once it is free
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_key_in    = res_key_ff;
               rsp_tag_in    = res_tag_ff;
               rsp_count_in  = count_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff        <= pos_in;
      key_ff        <= key_in;
      tag_ff        <= tag_in;
      res_status_ff <= res_status_in;
      res_key_ff    <= res_key_in;
      res_tag_ff    <= res_tag_in;
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // Response packing
   always_comb begin
      rsp_tdata                              = '0;
      rsp_tdata[KEY_WIDTH-1:0]               = rsp_key_ff;
      rsp_tdata[KEY_WIDTH +: TAG_WIDTH]      = rsp_tag_ff;
      rsp_tdata[ENTRY_W +: CNT_W]            = rsp_count_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule
